FILE: rtl/bcc_pkg.sv
// Shared types, widths and codes for the brick crop and cull block.
package bcc_pkg;

  localparam int COORD_W  = 32;
  localparam int DIM_W    = 9;
  localparam int LEVEL_W  = 4;
  localparam int BPV_W    = 4;
  localparam int IDX_W    = 16;
  localparam int OFFS_W   = 48;
  localparam int CFG_IDX_W = 3;
  localparam int EXT_W    = COORD_W + 2;                     // coord plus extent, no wrap
  localparam int SPAN_W   = DIM_W + (1 << LEVEL_W) - 1;      // dim << level
  localparam int VOL_W    = 3 * DIM_W + BPV_W;               // dx*dy*dz*bpv
  localparam int MUL_A_W  = 3 * DIM_W;
  localparam int MUL_B_W  = DIM_W;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_FIRST_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_FIRST_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_FIRST_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_LAST_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_LAST_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_LAST_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_VOXEL = 3'd6;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_AXIS,
    S_MUL,
    S_DONE
  } bcc_state_t;

  typedef enum logic {
    OP_OVLP,
    OP_MUL
  } bcc_op_t;

  typedef struct packed {
    bcc_op_t                    op;
    logic signed [COORD_W-1:0]  lower;
    logic [DIM_W-1:0]           dim;
    logic [LEVEL_W-1:0]         level;
    logic signed [COORD_W-1:0]  first;
    logic signed [COORD_W-1:0]  last;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
  } bcc_alu_req_t;

  typedef struct packed {
    logic                       overlap;
    logic [COORD_W-1:0]         diff;
    logic [MUL_P_W-1:0]         prod;
  } bcc_alu_rsp_t;

endpackage

FILE: rtl/bcc_alu.sv
// Shared arithmetic unit: one-axis overlap test with corner shift, or one multiply step.
module bcc_alu (
  input  bcc_pkg::bcc_alu_req_t req,
  output bcc_pkg::bcc_alu_rsp_t rsp
);

  logic [bcc_pkg::SPAN_W-1:0]       span;
  logic signed [bcc_pkg::EXT_W-1:0] lo_e;
  logic signed [bcc_pkg::EXT_W-1:0] hi_e;
  logic signed [bcc_pkg::EXT_W-1:0] f_e;
  logic signed [bcc_pkg::EXT_W-1:0] l_e;

  always_comb begin
    span = {{(bcc_pkg::SPAN_W-bcc_pkg::DIM_W){1'b0}}, req.dim} << req.level;
    lo_e = {{(bcc_pkg::EXT_W-bcc_pkg::COORD_W){req.lower[bcc_pkg::COORD_W-1]}}, req.lower};
    f_e  = {{(bcc_pkg::EXT_W-bcc_pkg::COORD_W){req.first[bcc_pkg::COORD_W-1]}}, req.first};
    l_e  = {{(bcc_pkg::EXT_W-bcc_pkg::COORD_W){req.last[bcc_pkg::COORD_W-1]}}, req.last};
    hi_e = lo_e + $signed({{(bcc_pkg::EXT_W-bcc_pkg::SPAN_W){1'b0}}, span});

    rsp.overlap = 1'b0;
    rsp.diff    = '0;
    rsp.prod    = '0;
    unique case (req.op)
      bcc_pkg::OP_OVLP: begin
        // min(hi, last) > max(lower, first)
        rsp.overlap = (hi_e > lo_e) && (hi_e > f_e) && (l_e > lo_e) && (l_e > f_e);
        rsp.diff    = req.lower - req.first;
      end
      bcc_pkg::OP_MUL: begin
        rsp.prod = {{bcc_pkg::MUL_B_W{1'b0}}, req.mul_a} *
                   {{bcc_pkg::MUL_A_W{1'b0}}, req.mul_b};
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/brick_crop_cull_top.sv
// Brick crop and cull: top level with sequencer, configuration registers and offset state.
// One brick is taken at a time. After acceptance a sequencer drives one shared arithmetic
// unit: it tests the x, y and z axes in turn against the crop box (stopping at the first
// empty axis), then multiplies dx*dy, then *dz, then *bytes_per_voxel, and a done state
// posts the result of a kept brick and adds the volume to the running byte offset. The
// block is ready again when it returns to idle after the done state.
// The result sits in an output register, so the next brick is accepted while it waits;
// the posting cycle stalls only if the previous result has not yet been taken.
module brick_crop_cull_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bcc_pkg::COORD_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_first_brick,
  input  logic signed [bcc_pkg::COORD_W-1:0]   in_brick_lower_x,
  input  logic signed [bcc_pkg::COORD_W-1:0]   in_brick_lower_y,
  input  logic signed [bcc_pkg::COORD_W-1:0]   in_brick_lower_z,
  input  logic [bcc_pkg::DIM_W-1:0]            in_brick_dim_x,
  input  logic [bcc_pkg::DIM_W-1:0]            in_brick_dim_y,
  input  logic [bcc_pkg::DIM_W-1:0]            in_brick_dim_z,
  input  logic [bcc_pkg::LEVEL_W-1:0]          in_brick_level,
  input  logic [bcc_pkg::IDX_W-1:0]            in_brick_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bcc_pkg::COORD_W-1:0]   out_lower_x,
  output logic signed [bcc_pkg::COORD_W-1:0]   out_lower_y,
  output logic signed [bcc_pkg::COORD_W-1:0]   out_lower_z,
  output logic [bcc_pkg::DIM_W-1:0]            out_dim_x,
  output logic [bcc_pkg::DIM_W-1:0]            out_dim_y,
  output logic [bcc_pkg::DIM_W-1:0]            out_dim_z,
  output logic [bcc_pkg::LEVEL_W-1:0]          out_level,
  output logic [bcc_pkg::OFFS_W-1:0]           out_byte_offset,
  output logic [bcc_pkg::IDX_W-1:0]            out_source_index
);

  // configuration
  logic signed [bcc_pkg::COORD_W-1:0] crop_first_x_r, crop_first_y_r, crop_first_z_r;
  logic signed [bcc_pkg::COORD_W-1:0] crop_last_x_r, crop_last_y_r, crop_last_z_r;
  logic [bcc_pkg::BPV_W-1:0]          bpv_r;

  // control
  bcc_pkg::bcc_state_t state_r, state_nxt;
  logic [1:0]          step_r, step_nxt;
  logic                keep_r, keep_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [bcc_pkg::OFFS_W-1:0] offset_r, offset_nxt;

  // latched brick
  logic signed [bcc_pkg::COORD_W-1:0] lower_r [3];
  logic [bcc_pkg::DIM_W-1:0]          dim_r [3];
  logic [bcc_pkg::LEVEL_W-1:0]        level_r;
  logic [bcc_pkg::IDX_W-1:0]          index_r;
  logic [bcc_pkg::COORD_W-1:0]        diff_r [3];
  logic [bcc_pkg::VOL_W-1:0]          vol_r, vol_nxt;

  // output register
  logic [bcc_pkg::COORD_W-1:0] o_lower_r [3];
  logic [bcc_pkg::DIM_W-1:0]   o_dim_r [3];
  logic [bcc_pkg::LEVEL_W-1:0] o_level_r;
  logic [bcc_pkg::OFFS_W-1:0]  o_offset_r;
  logic [bcc_pkg::IDX_W-1:0]   o_index_r;

  bcc_pkg::bcc_alu_req_t alu_req;
  bcc_pkg::bcc_alu_rsp_t alu_rsp;

  logic in_fire;
  logic post;

  bcc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_ready = (state_r == bcc_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crop_first_x_r <= '0;
      crop_first_y_r <= '0;
      crop_first_z_r <= '0;
      crop_last_x_r  <= '0;
      crop_last_y_r  <= '0;
      crop_last_z_r  <= '0;
      bpv_r          <= bcc_pkg::BPV_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bcc_pkg::CFG_CROP_FIRST_X:    crop_first_x_r <= cfg_data;
        bcc_pkg::CFG_CROP_FIRST_Y:    crop_first_y_r <= cfg_data;
        bcc_pkg::CFG_CROP_FIRST_Z:    crop_first_z_r <= cfg_data;
        bcc_pkg::CFG_CROP_LAST_X:     crop_last_x_r  <= cfg_data;
        bcc_pkg::CFG_CROP_LAST_Y:     crop_last_y_r  <= cfg_data;
        bcc_pkg::CFG_CROP_LAST_Z:     crop_last_z_r  <= cfg_data;
        bcc_pkg::CFG_BYTES_PER_VOXEL: bpv_r <= cfg_data[bcc_pkg::BPV_W-1:0];
        default: ;
      endcase
    end
  end

  // shared unit operand select
  always_comb begin
    alu_req       = '0;
    alu_req.level = level_r;
    if (state_r == bcc_pkg::S_MUL) begin
      alu_req.op = bcc_pkg::OP_MUL;
      unique case (step_r)
        2'd0: begin
          alu_req.mul_a = {{(bcc_pkg::MUL_A_W-bcc_pkg::DIM_W){1'b0}}, dim_r[0]};
          alu_req.mul_b = dim_r[1];
        end
        2'd1: begin
          alu_req.mul_a = vol_r[bcc_pkg::MUL_A_W-1:0];
          alu_req.mul_b = dim_r[2];
        end
        default: begin
          alu_req.mul_a = vol_r[bcc_pkg::MUL_A_W-1:0];
          alu_req.mul_b = {{(bcc_pkg::MUL_B_W-bcc_pkg::BPV_W){1'b0}}, bpv_r};
        end
      endcase
    end else begin
      alu_req.op = bcc_pkg::OP_OVLP;
      unique case (step_r)
        bcc_pkg::AXIS_X: begin
          alu_req.lower = lower_r[0];
          alu_req.dim   = dim_r[0];
          alu_req.first = crop_first_x_r;
          alu_req.last  = crop_last_x_r;
        end
        bcc_pkg::AXIS_Y: begin
          alu_req.lower = lower_r[1];
          alu_req.dim   = dim_r[1];
          alu_req.first = crop_first_y_r;
          alu_req.last  = crop_last_y_r;
        end
        default: begin
          alu_req.lower = lower_r[2];
          alu_req.dim   = dim_r[2];
          alu_req.first = crop_first_z_r;
          alu_req.last  = crop_last_z_r;
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    keep_nxt      = keep_r;
    vol_nxt       = vol_r;
    offset_nxt    = offset_r;
    out_valid_nxt = out_valid_r && !out_ready;
    post          = 1'b0;
    unique case (state_r)
      bcc_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = bcc_pkg::S_AXIS;
          step_nxt  = bcc_pkg::AXIS_X;
          keep_nxt  = 1'b1;
          if (in_first_brick) begin
            offset_nxt = '0;
          end
        end
      end
      bcc_pkg::S_AXIS: begin
        if (!alu_rsp.overlap) begin
          keep_nxt  = 1'b0;
          state_nxt = bcc_pkg::S_DONE;
        end else if (step_r == bcc_pkg::AXIS_Z) begin
          state_nxt = bcc_pkg::S_MUL;
          step_nxt  = 2'd0;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      bcc_pkg::S_MUL: begin
        vol_nxt = alu_rsp.prod[bcc_pkg::VOL_W-1:0];
        if (step_r == 2'd2) begin
          state_nxt = bcc_pkg::S_DONE;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      bcc_pkg::S_DONE: begin
        if (!keep_r) begin
          state_nxt = bcc_pkg::S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          post          = 1'b1;
          out_valid_nxt = 1'b1;
          offset_nxt    = offset_r +
                          {{(bcc_pkg::OFFS_W-bcc_pkg::VOL_W){1'b0}}, vol_r};
          state_nxt     = bcc_pkg::S_IDLE;
        end
      end
      default: state_nxt = bcc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcc_pkg::S_IDLE;
      step_r      <= '0;
      keep_r      <= 1'b0;
      out_valid_r <= 1'b0;
      offset_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      keep_r      <= keep_nxt;
      out_valid_r <= out_valid_nxt;
      offset_r    <= offset_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    vol_r <= vol_nxt;
    if (in_fire) begin
      lower_r[0] <= in_brick_lower_x;
      lower_r[1] <= in_brick_lower_y;
      lower_r[2] <= in_brick_lower_z;
      dim_r[0]   <= in_brick_dim_x;
      dim_r[1]   <= in_brick_dim_y;
      dim_r[2]   <= in_brick_dim_z;
      level_r    <= in_brick_level;
      index_r    <= in_brick_index;
    end
    if (state_r == bcc_pkg::S_AXIS) begin
      unique case (step_r)
        bcc_pkg::AXIS_X: diff_r[0] <= alu_rsp.diff;
        bcc_pkg::AXIS_Y: diff_r[1] <= alu_rsp.diff;
        default:         diff_r[2] <= alu_rsp.diff;
      endcase
    end
    if (post) begin
      o_lower_r[0] <= diff_r[0];
      o_lower_r[1] <= diff_r[1];
      o_lower_r[2] <= diff_r[2];
      o_dim_r[0]   <= dim_r[0];
      o_dim_r[1]   <= dim_r[1];
      o_dim_r[2]   <= dim_r[2];
      o_level_r    <= level_r;
      o_offset_r   <= offset_r;
      o_index_r    <= index_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lower_x      = o_lower_r[0];
  assign out_lower_y      = o_lower_r[1];
  assign out_lower_z      = o_lower_r[2];
  assign out_dim_x        = o_dim_r[0];
  assign out_dim_y        = o_dim_r[1];
  assign out_dim_z        = o_dim_r[2];
  assign out_level        = o_level_r;
  assign out_byte_offset  = o_offset_r;
  assign out_source_index = o_index_r;

endmodule

FILE: test/brick_crop_cull_top_tb.sv
// Self-checking testbench for brick_crop_cull_top: crop-box culling and running byte offset.
module brick_crop_cull_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W   = bcc_pkg::COORD_W;
  localparam int DIM_W     = bcc_pkg::DIM_W;
  localparam int LEVEL_W   = bcc_pkg::LEVEL_W;
  localparam int BPV_W     = bcc_pkg::BPV_W;
  localparam int IDX_W     = bcc_pkg::IDX_W;
  localparam int OFFS_W    = bcc_pkg::OFFS_W;
  localparam int CFG_IDX_W = bcc_pkg::CFG_IDX_W;

  localparam int LIMIT_CYCLES  = 400_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_BOUND   = 4000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_BRICKS  = 210;
  localparam int MAX_VOL_BRICKS = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int C_MIN = 32'sh8000_0000;
  localparam int C_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic               first;
    logic [COORD_W-1:0] lx, ly, lz;
    logic [DIM_W-1:0]   dx, dy, dz;
    logic [LEVEL_W-1:0] level;
    logic [IDX_W-1:0]   index;
  } brick_t;

  typedef struct packed {
    logic [COORD_W-1:0] lx, ly, lz;
    logic [DIM_W-1:0]   dx, dy, dz;
    logic [LEVEL_W-1:0] level;
    logic [OFFS_W-1:0]  offset;
    logic [IDX_W-1:0]   index;
  } brick_result_t;

  class crop_ledger;
    logic [COORD_W-1:0] box_lo [3];
    logic [COORD_W-1:0] box_hi [3];
    logic [BPV_W-1:0]   bpv;
    logic [OFFS_W-1:0]  run_offset;
    brick_result_t      kept_q [$];
    int mismatches, kept, culled, checked;

    function new();
      foreach (box_lo[a]) begin
        box_lo[a] = '0;
        box_hi[a] = '0;
      end
      bpv = BPV_W'(1);
      run_offset = '0;
      mismatches = 0;
      kept = 0;
      culled = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
      case (idx)
        bcc_pkg::CFG_CROP_FIRST_X:    box_lo[0] = data;
        bcc_pkg::CFG_CROP_FIRST_Y:    box_lo[1] = data;
        bcc_pkg::CFG_CROP_FIRST_Z:    box_lo[2] = data;
        bcc_pkg::CFG_CROP_LAST_X:     box_hi[0] = data;
        bcc_pkg::CFG_CROP_LAST_Y:     box_hi[1] = data;
        bcc_pkg::CFG_CROP_LAST_Z:     box_hi[2] = data;
        bcc_pkg::CFG_BYTES_PER_VOXEL: bpv = data[BPV_W-1:0];
        default: ;
      endcase
    endfunction

    // brick upper end is formed in 64 bits, so it never wraps
    function bit axis_kept(logic [COORD_W-1:0] lower, logic [DIM_W-1:0] dim,
                           logic [LEVEL_W-1:0] lvl, int a);
      longint lo, hi, f, l, start, stop;
      lo = longint'($signed(lower));
      hi = lo + (longint'(dim) << lvl);
      f = longint'($signed(box_lo[a]));
      l = longint'($signed(box_hi[a]));
      start = (lo > f) ? lo : f;
      stop = (hi < l) ? hi : l;
      return stop > start;
    endfunction

    function void note_brick(brick_t b);
      brick_result_t r;
      logic [OFFS_W-1:0] vol;
      if (b.first) run_offset = '0;
      if (!(axis_kept(b.lx, b.dx, b.level, 0) && axis_kept(b.ly, b.dy, b.level, 1) &&
            axis_kept(b.lz, b.dz, b.level, 2))) begin
        culled++;
        return;
      end
      r.lx = b.lx - box_lo[0];
      r.ly = b.ly - box_lo[1];
      r.lz = b.lz - box_lo[2];
      r.dx = b.dx;
      r.dy = b.dy;
      r.dz = b.dz;
      r.level = b.level;
      r.offset = run_offset;
      r.index = b.index;
      vol = OFFS_W'(b.dx) * OFFS_W'(b.dy) * OFFS_W'(b.dz) * OFFS_W'(bpv);
      run_offset = run_offset + vol;
      kept_q = {kept_q, r};
      kept++;
    endfunction

    function void check_result(brick_result_t got);
      brick_result_t exp;
      string bad;
      bad = "";
      if (kept_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result beat, source index %0d", got.index);
        return;
      end
      exp = kept_q.pop_front();
      checked++;
      if (got.lx !== exp.lx) bad = {bad, " lower_x"};
      if (got.ly !== exp.ly) bad = {bad, " lower_y"};
      if (got.lz !== exp.lz) bad = {bad, " lower_z"};
      if (got.dx !== exp.dx) bad = {bad, " dim_x"};
      if (got.dy !== exp.dy) bad = {bad, " dim_y"};
      if (got.dz !== exp.dz) bad = {bad, " dim_z"};
      if (got.level !== exp.level) bad = {bad, " level"};
      if (got.offset !== exp.offset) bad = {bad, " byte_offset"};
      if (got.index !== exp.index) bad = {bad, " source_index"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on result %0d:%s", checked, bad);
          $display("  expected lower %0d/%0d/%0d dims %0d/%0d/%0d lvl %0d offs %0d idx %0d",
                   $signed(exp.lx), $signed(exp.ly), $signed(exp.lz), exp.dx, exp.dy, exp.dz,
                   exp.level, exp.offset, exp.index);
          $display("  actual   lower %0d/%0d/%0d dims %0d/%0d/%0d lvl %0d offs %0d idx %0d",
                   $signed(got.lx), $signed(got.ly), $signed(got.lz), got.dx, got.dy, got.dz,
                   got.level, got.offset, got.index);
        end
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [COORD_W-1:0]            cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_first_brick;
  logic signed [COORD_W-1:0]     in_brick_lower_x, in_brick_lower_y, in_brick_lower_z;
  logic [DIM_W-1:0]              in_brick_dim_x, in_brick_dim_y, in_brick_dim_z;
  logic [LEVEL_W-1:0]            in_brick_level;
  logic [IDX_W-1:0]              in_brick_index;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [COORD_W-1:0]     out_lower_x, out_lower_y, out_lower_z;
  logic [DIM_W-1:0]              out_dim_x, out_dim_y, out_dim_z;
  logic [LEVEL_W-1:0]            out_level;
  logic [OFFS_W-1:0]             out_byte_offset;
  logic [IDX_W-1:0]              out_source_index;

  brick_t        cur_brick = '0;
  brick_result_t seen_result;
  crop_ledger    ledger = new();
  int            cycles = 0;
  int            in_beats = 0;
  int            out_beats = 0;
  int            settings = 0;
  bit            calm = 1'b0;

  assign in_first_brick   = cur_brick.first;
  assign in_brick_lower_x = cur_brick.lx;
  assign in_brick_lower_y = cur_brick.ly;
  assign in_brick_lower_z = cur_brick.lz;
  assign in_brick_dim_x   = cur_brick.dx;
  assign in_brick_dim_y   = cur_brick.dy;
  assign in_brick_dim_z   = cur_brick.dz;
  assign in_brick_level   = cur_brick.level;
  assign in_brick_index   = cur_brick.index;
  assign seen_result = {out_lower_x, out_lower_y, out_lower_z, out_dim_x, out_dim_y, out_dim_z,
                        out_level, out_byte_offset, out_source_index};

  brick_crop_cull_top u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // beat monitor; results are checked ahead of new bricks taken at the same edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        ledger.check_result(seen_result);
        out_beats++;
      end
      if (in_valid && in_ready) begin
        ledger.note_brick(cur_brick);
        in_beats++;
      end
    end
  end

  // result side: random stall before each beat, none while calm
  initial begin : result_sink
    int stall, seen;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      seen = out_beats;
      do @(negedge clk); while (out_beats == seen);
    end
  end

  task automatic send_brick(input brick_t b);
    int gap, seen;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_brick = b;
    in_valid = 1'b1;
    seen = in_beats;
    do @(negedge clk); while (in_beats == seen);
  endtask

  // culled bricks leave no trace in the queue, so allow for one still in flight
  task automatic settle();
    int waited;
    in_valid = 1'b0;
    waited = 0;
    while (ledger.kept_q.size() != 0 && waited < DRAIN_BOUND) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    ledger.write_reg(idx, data);
  endtask

  task automatic set_box(input int fx, fy, fz, lx, ly, lz, input logic [COORD_W-1:0] bpv_word);
    settle();
    write_reg(bcc_pkg::CFG_CROP_FIRST_X, fx);
    write_reg(bcc_pkg::CFG_CROP_FIRST_Y, fy);
    write_reg(bcc_pkg::CFG_CROP_FIRST_Z, fz);
    write_reg(bcc_pkg::CFG_CROP_LAST_X, lx);
    write_reg(bcc_pkg::CFG_CROP_LAST_Y, ly);
    write_reg(bcc_pkg::CFG_CROP_LAST_Z, lz);
    write_reg(bcc_pkg::CFG_BYTES_PER_VOXEL, bpv_word);
    settings++;
  endtask

  function automatic brick_t mk(bit first, int lx, ly, lz, int dx, dy, dz, int lvl, int idx);
    brick_t b;
    b.first = first;
    b.lx = lx;
    b.ly = ly;
    b.lz = lz;
    b.dx = DIM_W'(dx);
    b.dy = DIM_W'(dy);
    b.dz = DIM_W'(dz);
    b.level = LEVEL_W'(lvl);
    b.index = IDX_W'(idx);
    return b;
  endfunction

  function automatic void pick_span(output int f, output int l);
    longint top;
    f = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2000)) - 1000 : int'($urandom);
    top = longint'(f) + longint'($urandom_range(1, 1 << 20));
    l = (top > longint'(C_MAX)) ? C_MAX : int'(top);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 13) return DIM_W'($urandom_range(257, 511));
    return DIM_W'($urandom_range(1, 256));
  endfunction

  // mostly straddles or sits inside the crop span so that most bricks survive
  function automatic logic [COORD_W-1:0] pick_coord(int a, logic [DIM_W-1:0] dim,
                                                    logic [LEVEL_W-1:0] lvl);
    longint f, l, ext;
    f = longint'($signed(ledger.box_lo[a]));
    l = longint'($signed(ledger.box_hi[a]));
    if (l <= f || $urandom_range(0, 6) == 0) return $urandom;
    ext = (longint'(dim) << lvl) + 1;
    return COORD_W'(f + longint'($urandom_range(0, 32'(l - f - 1)))
                    - longint'($urandom_range(0, 32'(ext))));
  endfunction

  function automatic brick_t rand_brick();
    brick_t b;
    b.first = ($urandom_range(0, 19) == 0);
    b.level = ($urandom_range(0, 9) < 7) ? LEVEL_W'($urandom_range(0, 4))
                                         : LEVEL_W'($urandom_range(0, 15));
    b.dx = pick_dim();
    b.dy = pick_dim();
    b.dz = pick_dim();
    b.lx = pick_coord(0, b.dx, b.level);
    b.ly = pick_coord(1, b.dy, b.level);
    b.lz = pick_coord(2, b.dz, b.level);
    b.index = IDX_W'($urandom_range(0, 65535));
    return b;
  endfunction

  initial begin
    int fa [3];
    int la [3];
    logic [BPV_W-1:0] bpv;
    logic [COORD_W-1:0] bpv_word;
    int leftover;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset box is empty: everything culls
    send_brick(mk(1, 10, 10, 10, 4, 4, 4, 0, 16'hFFFF));

    set_box(-1000, -2000, -3000, 5000, 6000, 7000, 8);
    send_brick(mk(1, 0, 0, 0, 1, 1, 1, 0, 0));
    send_brick(mk(0, -1100, 0, 0, 100, 10, 10, 0, 1));      // ends exactly at crop start
    send_brick(mk(0, -1100, 0, 0, 101, 10, 10, 0, 2));
    send_brick(mk(0, 0, 6000, 0, 5, 5, 5, 0, 3));           // starts exactly at crop end
    send_brick(mk(0, 0, 5999, 0, 5, 5, 5, 0, 4));
    send_brick(mk(0, 0, 0, -3000 - 32768 + 1, 1, 1, 1, 15, 5));
    send_brick(mk(0, 0, 0, 0, 256, 256, 256, 0, 16'hFFFF));
    send_brick(mk(0, 0, 0, 0, 0, 256, 256, 0, 6));
    send_brick(mk(0, C_MIN, C_MIN, C_MIN, 511, 511, 511, 15, 7));
    send_brick(mk(0, C_MAX, C_MAX, C_MAX, 511, 511, 511, 15, 8));
    send_brick(mk(1, 0, 0, 0, 8, 0, 8, 3, 9));              // culled, still clears offset
    send_brick(mk(0, 1, 2, 3, 2, 3, 4, 1, 10));

    // full range box, 15 bytes/voxel with junk in the upper data bits
    set_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 32'hA5A5_A5AF);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    send_brick(mk(0, C_MAX - 1, 0, 0, 1, 1, 1, 0, 11));     // corner difference wraps
    send_brick(mk(0, C_MAX - 5, C_MAX - 5, C_MAX - 5, 511, 511, 511, 15, 12));
    send_brick(mk(0, C_MIN, C_MIN, C_MIN, 511, 511, 511, 15, 13));
    send_brick(mk(0, C_MAX, 0, 0, 511, 1, 1, 15, 14));

    set_box(100, 100, 100, -100, -100, -100, 0);            // inverted box
    send_brick(mk(0, 0, 0, 0, 256, 256, 256, 0, 15));
    send_brick(mk(0, -200, -200, -200, 511, 511, 511, 4, 16));

    set_box(-50, -50, -50, 50, 50, 50, 0);
    send_brick(mk(1, -60, -60, -60, 20, 20, 20, 0, 17));
    send_brick(mk(0, 49, 49, 49, 1, 1, 1, 0, 18));

    for (int p = 0; p < RAND_PHASES; p++) begin
      for (int a = 0; a < 3; a++) pick_span(fa[a], la[a]);
      if (p == 0) begin
        fa = '{C_MIN, C_MIN, C_MIN};
        la = '{C_MAX, C_MAX, C_MAX};
      end
      if (p == 3) la[1] = fa[1] - int'($urandom_range(0, 1000));
      bpv = BPV_W'((p == 0) ? 8 : (p == 1) ? 1 : (p == 2) ? 0 : int'($urandom_range(0, 15)));
      bpv_word = p[0] ? (($urandom & ~32'hF) | bpv) : COORD_W'(bpv);
      set_box(fa[0], fa[1], fa[2], la[0], la[1], la[2], bpv_word);
      for (int n = 0; n < PHASE_BRICKS; n++) begin
        if (n % 40 == 0) calm = (p % 3 == 2) || ($urandom_range(0, 4) == 0);
        send_brick(rand_brick());
      end
    end

    // back-to-back max-volume bricks at the largest bytes per voxel
    calm = 1'b1;
    set_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 15);
    for (int k = 0; k < MAX_VOL_BRICKS; k++)
      send_brick(mk(k == 0, 0, 0, 0, 511, 511, 511, 0, k));
    calm = 1'b0;
    for (int k = 0; k < 20; k++) send_brick(rand_brick());

    settle();
    leftover = ledger.kept_q.size();
    if (leftover != 0) begin
      ledger.mismatches += leftover;
      $display("%0d expected results never arrived", leftover);
    end
    $display("Run: %0d bricks over %0d crop settings, %0d results checked, %0d bricks culled",
             in_beats, settings, ledger.checked, ledger.culled);
    $display("Covered edge-touching, empty and inverted boxes, odd dims and max-volume bricks;"
             , " %0d mismatches", ledger.mismatches);
    if (ledger.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
